### sv/triangle_barycentric_map_macros.svh
// ---------------------------------------------------------------------------
// Triangle barycentric map: assertion macros
// Clocked property shorthands shared by the checker.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_BARYCENTRIC_MAP_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_MAP_MACROS_SVH

// Same-cycle implication, off while in reset.
`define TBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define TBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define TBM_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### sv/tbm_pkg.sv
// ---------------------------------------------------------------------------
// Triangle barycentric map: package
// Shared constants, register indexes and control structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbm_pkg;

  localparam int COORD_BITS_DEF       = 20;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;
  localparam int WBITS                = 24;
  localparam int QCLAMP_LOG           = 40;
  localparam int CFG_INDEX_BITS       = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SRC_A = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SRC_B = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SRC_C = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DST_A = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DST_B = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DST_C = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE  = 3'd6;

  typedef struct packed {
    logic dst_3d;
    logic src_3d;
  } mode_t;

  localparam mode_t MODE_RESET = 2'b11;

  typedef struct packed {
    logic busy;
    logic det_zero;
  } drv_status_t;

endpackage

### sv/tbm_point_if.sv
// ---------------------------------------------------------------------------
// Triangle barycentric map: point channel
// Valid/ready channel carrying one query point per word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tbm_point_if #(
  parameter int COORD_BITS = tbm_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

### sv/tbm_result_if.sv
// ---------------------------------------------------------------------------
// Triangle barycentric map: result channel
// Valid/ready channel carrying weights, flags and the mapped point.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tbm_result_if #(
  parameter int COORD_BITS = tbm_pkg::COORD_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic signed [tbm_pkg::WBITS-1:0] bary_u;
  logic signed [tbm_pkg::WBITS-1:0] bary_v;
  logic signed [tbm_pkg::WBITS-1:0] bary_w;
  logic                             inside_res;
  logic                             degenerate;
  logic signed [COORD_BITS-1:0]     mapped_x;
  logic signed [COORD_BITS-1:0]     mapped_y;
  logic signed [COORD_BITS-1:0]     mapped_z;
  logic                             saturated;

  modport source (output valid, bary_u, bary_v, bary_w, inside_res, degenerate,
                  mapped_x, mapped_y, mapped_z, saturated, input ready);
  modport sink   (input valid, bary_u, bary_v, bary_w, inside_res, degenerate,
                  mapped_x, mapped_y, mapped_z, saturated, output ready);
endinterface

### sv/tbm_cfg_if.sv
// ---------------------------------------------------------------------------
// Triangle barycentric map: configuration channel
// Valid/ready write channel carrying a register index and its data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tbm_cfg_if #(
  parameter int COORD_BITS = tbm_pkg::COORD_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic [tbm_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [3*COORD_BITS-1:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/triangle_barycentric_map.sv
// ---------------------------------------------------------------------------
// Triangle barycentric map
// Barycentric weights of a point on a source triangle, mapped to a target.
// ---------------------------------------------------------------------------
// Usage:
//   point  : one query point per word (x, y, z; z ignored for a 2D source).
//   result : u, v, w weights, inside and degenerate flags, mapped point and
//            saturation flag, one word per point, in order.
//   cfg    : register writes (index 0..6); ready is always high.
// Pipeline: 6 front stages, 44 divider stages and 4 mapping stages feed
//   the output queue.
// Throughput: one point per cycle when not stalled or busy. The 41-bit
//   quotient is resolved one bit per stage in the divider lanes for v and w.
// Reset and register writes: the setup unit recomputes the edge products and
//   determinant; point ready stays low until that is done.
// Stall: a two-word output queue sits behind the pipe. The pipe and point
//   ready advance while the queue has room, so a new point is taken while one
//   result waits; with the queue full everything holds in place.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_barycentric_map #(
  parameter int COORD_BITS       = tbm_pkg::COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = tbm_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tbm_point_if.sink   point,
  tbm_result_if.source result,
  tbm_cfg_if.sink     cfg
);
  localparam int C        = COORD_BITS;
  localparam int E        = C + 1;
  localparam int D        = 2 * C + 4;
  localparam int DW       = 2 * D;
  localparam int NW       = DW + 1;
  localparam int OW       = tbm_pkg::QCLAMP_LOG + 2;
  localparam int WB       = tbm_pkg::WBITS;
  localparam int FRONT    = 6;
  localparam int QDEPTH   = 2;
  localparam int EW       = 3 * WB + 3 * C + 3;

  // configuration registers
  logic [3*C-1:0]       src_a, src_b, src_c;
  logic [3*C-1:0]       dst [3];
  tbm_pkg::mode_t       mode;
  logic                 cfg_wr;

  // setup unit outputs
  logic signed [C-1:0]  a_crd [3];
  logic signed [E-1:0]  e0 [3];
  logic signed [E-1:0]  e1 [3];
  logic signed [D-1:0]  d00, d01, d11;
  logic [DW-1:0]        det;
  tbm_pkg::drv_status_t status;

  // front pipe
  logic                  adv;
  logic                  accept;
  logic [FRONT-1:0]      fvld;
  logic signed [C-1:0]   pz;
  logic signed [E-1:0]   e2 [3];
  logic signed [2*E-1:0] pr20 [3];
  logic signed [2*E-1:0] pr21 [3];
  logic signed [D-1:0]   d20, d21;
  logic signed [DW-1:0]  p0, p1, p2, p3;
  logic signed [NW-1:0]  numv, numw;

  // divider and mapping
  logic                  vv, wv;
  logic signed [OW-1:0]  qv, qw;
  logic                  mvld;
  logic signed [WB-1:0]  m_u, m_v, m_w;
  logic                  m_ins, m_deg, m_sat;
  logic signed [C-1:0]   m_x, m_y, m_z;

  // output queue
  logic [EW-1:0]         qmem [QDEPTH];
  logic                  wr_ptr, rd_ptr;
  logic [1:0]            qcnt;
  logic                  push, pop;
  logic [EW-1:0]         head;

  // ------------------------------------------------------------ config
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_a  <= '0;
      src_b  <= '0;
      src_c  <= '0;
      dst[0] <= '0;
      dst[1] <= '0;
      dst[2] <= '0;
      mode   <= tbm_pkg::MODE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg.index)
        tbm_pkg::REG_SRC_A: src_a  <= cfg.data;
        tbm_pkg::REG_SRC_B: src_b  <= cfg.data;
        tbm_pkg::REG_SRC_C: src_c  <= cfg.data;
        tbm_pkg::REG_DST_A: dst[0] <= cfg.data;
        tbm_pkg::REG_DST_B: dst[1] <= cfg.data;
        tbm_pkg::REG_DST_C: dst[2] <= cfg.data;
        tbm_pkg::REG_MODE:  mode   <= tbm_pkg::mode_t'(cfg.data[1:0]);
        default: ;  // drop writes past the register list
      endcase
    end
  end

  tbm_derive #(.COORD_BITS(C)) u_derive (
    .clk(clk), .rst(rst), .restart(cfg_wr), .mode(mode),
    .src_a(src_a), .src_b(src_b), .src_c(src_c),
    .a_crd(a_crd), .e0(e0), .e1(e1),
    .d00(d00), .d01(d01), .d11(d11), .det(det), .status(status)
  );

  // ------------------------------------------------------------ front pipe
  // advance the whole pipe while the output queue has room
  assign adv         = (qcnt < 2'(QDEPTH));
  assign point.ready = adv && !status.busy;
  assign accept      = point.valid && point.ready;
  assign pz          = mode.src_3d ? point.point_z : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvld <= '0;
    end else if (adv) begin
      fvld <= {fvld[FRONT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // point minus vertex A
      e2[0] <= E'(point.point_x) - E'(a_crd[0]);
      e2[1] <= E'(point.point_y) - E'(a_crd[1]);
      e2[2] <= E'(pz) - E'(a_crd[2]);
      for (int k = 0; k < 3; k++) begin
        pr20[k] <= e2[k] * e0[k];
        pr21[k] <= e2[k] * e1[k];
      end
      d20  <= D'(pr20[0]) + D'(pr20[1]) + D'(pr20[2]);
      d21  <= D'(pr21[0]) + D'(pr21[1]) + D'(pr21[2]);
      // weight numerators
      numv <= NW'(p0) - NW'(p1);
      numw <= NW'(p2) - NW'(p3);
    end
  end

  tbm_mul #(.AW(D), .BW(D)) u_mul_v0 (.clk(clk), .en(adv), .a(d11), .b(d20), .p(p0));
  tbm_mul #(.AW(D), .BW(D)) u_mul_v1 (.clk(clk), .en(adv), .a(d01), .b(d21), .p(p1));
  tbm_mul #(.AW(D), .BW(D)) u_mul_w0 (.clk(clk), .en(adv), .a(d00), .b(d21), .p(p2));
  tbm_mul #(.AW(D), .BW(D)) u_mul_w1 (.clk(clk), .en(adv), .a(d01), .b(d20), .p(p3));

  // ------------------------------------------------------------ divide
  tbm_div #(.DW(DW), .NW(NW), .WF(WEIGHT_FRAC_BITS)) u_div_v (
    .clk(clk), .rst(rst), .en(adv), .in_vld(fvld[FRONT-1]),
    .num(numv), .det(det), .out_vld(vv), .q(qv)
  );

  tbm_div #(.DW(DW), .NW(NW), .WF(WEIGHT_FRAC_BITS)) u_div_w (
    .clk(clk), .rst(rst), .en(adv), .in_vld(fvld[FRONT-1]),
    .num(numw), .det(det), .out_vld(wv), .q(qw)
  );

  // ------------------------------------------------------------ map
  tbm_map #(.COORD_BITS(C), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_map (
    .clk(clk), .rst(rst), .en(adv), .in_vld(vv && wv),
    .v(qv), .w(qw), .mode(mode), .det_zero(status.det_zero), .dst(dst),
    .out_vld(mvld), .bary_u(m_u), .bary_v(m_v), .bary_w(m_w),
    .inside_res(m_ins), .degenerate(m_deg),
    .mapped_x(m_x), .mapped_y(m_y), .mapped_z(m_z), .saturated(m_sat)
  );

  // ------------------------------------------------------------ output queue
  assign push = adv && mvld;
  assign pop  = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= {m_u, m_v, m_w, m_ins, m_deg, m_x, m_y, m_z, m_sat};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      qcnt   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   qcnt <= qcnt + 1'b1;
        2'b01:   qcnt <= qcnt - 1'b1;
        default: qcnt <= qcnt;
      endcase
    end
  end

  assign head              = qmem[rd_ptr];
  assign result.valid      = (qcnt != '0);
  assign result.bary_u     = head[EW-1 -: WB];
  assign result.bary_v     = head[EW-WB-1 -: WB];
  assign result.bary_w     = head[EW-2*WB-1 -: WB];
  assign result.inside_res = head[3*C+2];
  assign result.degenerate = head[3*C+1];
  assign result.mapped_x   = head[3*C -: C];
  assign result.mapped_y   = head[2*C -: C];
  assign result.mapped_z   = head[C -: C];
  assign result.saturated  = head[0];
endmodule

### sv/tbm_mul.sv
// ---------------------------------------------------------------------------
// Triangle barycentric map: split multiplier
// Signed product over two stages from four half-width partial products.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbm_mul #(
  parameter int AW = 44,
  parameter int BW = 44
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);
  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic        [AL-1:0]     a_lo;
  logic signed [AH-1:0]     a_hi;
  logic        [BL-1:0]     b_lo;
  logic signed [BH-1:0]     b_hi;
  logic        [AL+BL-1:0]  p_ll;
  logic signed [AL+BH:0]    p_lh;
  logic signed [AH+BL:0]    p_hl;
  logic signed [AH+BH-1:0]  p_hh;

  assign a_lo = a[AL-1:0];
  assign a_hi = a[AW-1:AL];
  assign b_lo = b[BL-1:0];
  assign b_hi = b[BW-1:BL];

  always_ff @(posedge clk) begin
    if (en) begin
      p_ll <= a_lo * b_lo;
      p_lh <= $signed({1'b0, a_lo}) * b_hi;
      p_hl <= a_hi * $signed({1'b0, b_lo});
      p_hh <= a_hi * b_hi;
      p    <= (PW'(p_hh) <<< (AL + BL)) + (PW'(p_lh) <<< AL)
            + (PW'(p_hl) <<< BL) + PW'(p_ll);
    end
  end
endmodule

### sv/tbm_derive.sv
// ---------------------------------------------------------------------------
// Triangle barycentric map: source triangle setup
// Edge vectors, edge dot products and Gram determinant from the registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbm_derive #(
  parameter int COORD_BITS = tbm_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               restart,
  input  tbm_pkg::mode_t                     mode,
  input  logic [3*COORD_BITS-1:0]            src_a,
  input  logic [3*COORD_BITS-1:0]            src_b,
  input  logic [3*COORD_BITS-1:0]            src_c,
  output logic signed [COORD_BITS-1:0]       a_crd [3],
  output logic signed [COORD_BITS:0]         e0 [3],
  output logic signed [COORD_BITS:0]         e1 [3],
  output logic signed [2*COORD_BITS+3:0]     d00,
  output logic signed [2*COORD_BITS+3:0]     d01,
  output logic signed [2*COORD_BITS+3:0]     d11,
  output logic [4*COORD_BITS+7:0]            det,
  output tbm_pkg::drv_status_t               status
);
  localparam int C    = COORD_BITS;
  localparam int E    = C + 1;
  localparam int D    = 2 * C + 4;
  localparam int DW   = 2 * D;
  localparam int DLAT = 6;
  localparam int CNTW = $clog2(DLAT + 1);

  logic signed [C-1:0]   ca [3];
  logic signed [C-1:0]   cb [3];
  logic signed [C-1:0]   cc [3];
  logic signed [2*E-1:0] sq00 [3];
  logic signed [2*E-1:0] sq01 [3];
  logic signed [2*E-1:0] sq11 [3];
  logic signed [DW-1:0]  m0;
  logic signed [DW-1:0]  m1;
  logic                  dz;
  logic [CNTW-1:0]       cnt;

  // z of a 2D source reads as zero
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (k == 2 && !mode.src_3d) begin
        ca[k] = '0;
        cb[k] = '0;
        cc[k] = '0;
      end else begin
        ca[k] = $signed(src_a[k*C +: C]);
        cb[k] = $signed(src_b[k*C +: C]);
        cc[k] = $signed(src_c[k*C +: C]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      a_crd[k] <= ca[k];
      e0[k]    <= E'(cb[k]) - E'(ca[k]);
      e1[k]    <= E'(cc[k]) - E'(ca[k]);
      sq00[k]  <= e0[k] * e0[k];
      sq01[k]  <= e0[k] * e1[k];
      sq11[k]  <= e1[k] * e1[k];
    end
    d00 <= D'(sq00[0]) + D'(sq00[1]) + D'(sq00[2]);
    d01 <= D'(sq01[0]) + D'(sq01[1]) + D'(sq01[2]);
    d11 <= D'(sq11[0]) + D'(sq11[1]) + D'(sq11[2]);
    // Gram determinant is never negative
    det <= $unsigned(m0 - m1);
  end

  tbm_mul #(.AW(D), .BW(D)) u_mul_det0 (
    .clk(clk), .en(1'b1), .a(d00), .b(d11), .p(m0)
  );

  tbm_mul #(.AW(D), .BW(D)) u_mul_det1 (
    .clk(clk), .en(1'b1), .a(d01), .b(d01), .p(m1)
  );

  // hold busy until a register change has reached the determinant
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= CNTW'(DLAT);
      dz  <= 1'b1;
    end else begin
      dz <= (m0 == m1);
      if (restart) begin
        cnt <= CNTW'(DLAT);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign status.busy     = (cnt != '0);
  assign status.det_zero = dz;
endmodule

### sv/tbm_div.sv
// ---------------------------------------------------------------------------
// Triangle barycentric map: weight divider
// Pipelined restoring divider, one quotient bit a stage, clamped magnitude.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbm_div #(
  parameter int DW = 88,
  parameter int NW = 89,
  parameter int WF = tbm_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic signed [NW-1:0]                 num,
  input  logic [DW-1:0]                        det,
  output logic                                 out_vld,
  output logic signed [tbm_pkg::QCLAMP_LOG+1:0] q
);
  localparam int QB = tbm_pkg::QCLAMP_LOG + 1;
  localparam int OW = QB + 1;
  localparam int RW = NW + WF + QB;
  localparam logic [QB-1:0] QCLAMP = QB'(1) << tbm_pkg::QCLAMP_LOG;

  logic          va;
  logic          nega;
  logic [RW-1:0] ra;
  logic          v_s   [QB+1];
  logic          neg_s [QB+1];
  logic          ovf_s [QB+1];
  logic [RW-1:0] r_s   [QB+1];
  logic [QB-1:0] q_s   [QB+1];
  logic [QB-1:0] mag;

  // take the magnitude and scale by the weight fraction
  always_ff @(posedge clk) begin
    if (en) begin
      nega <= num[NW-1];
      ra   <= RW'(num[NW-1] ? $unsigned(-num) : $unsigned(num)) << WF;
      neg_s[0] <= nega;
      // a quotient that needs more than QB bits clamps anyway
      ovf_s[0] <= (ra >= (RW'(det) << QB));
      r_s[0]   <= ra;
      q_s[0]   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va     <= 1'b0;
      v_s[0] <= 1'b0;
    end else if (en) begin
      va     <= in_vld;
      v_s[0] <= va;
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_bit
    localparam int B = QB - 1 - g;
    always_ff @(posedge clk) begin
      if (en) begin
        neg_s[g+1] <= neg_s[g];
        ovf_s[g+1] <= ovf_s[g];
        if (r_s[g] >= (RW'(det) << B)) begin
          r_s[g+1] <= r_s[g] - (RW'(det) << B);
          q_s[g+1] <= q_s[g] | (QB'(1) << B);
        end else begin
          r_s[g+1] <= r_s[g];
          q_s[g+1] <= q_s[g];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[g+1] <= 1'b0;
      end else if (en) begin
        v_s[g+1] <= v_s[g];
      end
    end
  end

  assign mag = (ovf_s[QB] || q_s[QB] > QCLAMP) ? QCLAMP : q_s[QB];

  always_ff @(posedge clk) begin
    if (en) begin
      q <= neg_s[QB] ? -$signed(OW'(mag)) : $signed(OW'(mag));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v_s[QB];
    end
  end
endmodule

### sv/tbm_map.sv
// ---------------------------------------------------------------------------
// Triangle barycentric map: weight finish and target mapping
// Third weight, inside test, saturation and the weighted target point.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbm_map #(
  parameter int COORD_BITS       = tbm_pkg::COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = tbm_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_vld,
  input  logic signed [tbm_pkg::QCLAMP_LOG+1:0] v,
  input  logic signed [tbm_pkg::QCLAMP_LOG+1:0] w,
  input  tbm_pkg::mode_t                        mode,
  input  logic                                  det_zero,
  input  logic [3*COORD_BITS-1:0]               dst [3],
  output logic                                  out_vld,
  output logic signed [tbm_pkg::WBITS-1:0]      bary_u,
  output logic signed [tbm_pkg::WBITS-1:0]      bary_v,
  output logic signed [tbm_pkg::WBITS-1:0]      bary_w,
  output logic                                  inside_res,
  output logic                                  degenerate,
  output logic signed [COORD_BITS-1:0]          mapped_x,
  output logic signed [COORD_BITS-1:0]          mapped_y,
  output logic signed [COORD_BITS-1:0]          mapped_z,
  output logic                                  saturated
);
  localparam int C  = COORD_BITS;
  localparam int WB = tbm_pkg::WBITS;
  localparam int OW = tbm_pkg::QCLAMP_LOG + 2;
  localparam int UW = OW + 2;
  localparam int PW = WB + C;
  localparam int AW = PW + 2;
  localparam logic signed [UW-1:0] ONE  = UW'(1) << WEIGHT_FRAC_BITS;
  localparam logic signed [UW-1:0] W_HI = UW'((1 << (WB - 1)) - 1);
  localparam logic signed [UW-1:0] W_LO = -W_HI - 1;
  localparam logic signed [AW-1:0] C_HI = AW'((1 << (C - 1)) - 1);
  localparam logic signed [AW-1:0] C_LO = -C_HI - 1;

  logic signed [UW-1:0] wraw [3];
  logic signed [WB-1:0] wsat [3];
  logic                 ins_c;
  logic                 clip_c;
  logic signed [WB-1:0] wt [3];
  logic signed [WB-1:0] wt2 [3];
  logic signed [WB-1:0] wt3 [3];
  logic                 ins1, clip1, ins2, clip2, ins3, clip3;
  logic [2:0]           vld;
  logic signed [PW-1:0] prod [3][3];
  logic signed [AW-1:0] acc [3];
  logic signed [AW-1:0] sh [3];
  logic signed [C-1:0]  msat [3];
  logic                 mclip;

  // third weight, inside test on unclipped values, clip to weight range
  always_comb begin
    wraw[0] = ONE - UW'(v) - UW'(w);
    wraw[1] = UW'(v);
    wraw[2] = UW'(w);
    ins_c   = 1'b1;
    clip_c  = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (!(wraw[k] > 0 && wraw[k] < ONE)) begin
        ins_c = 1'b0;
      end
      if (wraw[k] > W_HI) begin
        wsat[k] = WB'(W_HI);
        clip_c  = 1'b1;
      end else if (wraw[k] < W_LO) begin
        wsat[k] = WB'(W_LO);
        clip_c  = 1'b1;
      end else begin
        wsat[k] = WB'(wraw[k]);
      end
    end
  end

  // floor shift and clip; z of a 2D target is zeroed and not clipped
  always_comb begin
    mclip = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sh[k] = acc[k] >>> WEIGHT_FRAC_BITS;
      if (k == 2 && !mode.dst_3d) begin
        msat[k] = '0;
      end else if (sh[k] > C_HI) begin
        msat[k] = C'(C_HI);
        mclip   = 1'b1;
      end else if (sh[k] < C_LO) begin
        msat[k] = C'(C_LO);
        mclip   = 1'b1;
      end else begin
        msat[k] = C'(sh[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wt    <= wsat;
      ins1  <= ins_c;
      clip1 <= clip_c;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          prod[k][j] <= wt[j] * $signed(dst[j][k*C +: C]);
        end
      end
      ins2  <= ins1;
      clip2 <= clip1;
      for (int k = 0; k < 3; k++) begin
        acc[k] <= AW'(prod[k][0]) + AW'(prod[k][1]) + AW'(prod[k][2]);
      end
      ins3  <= ins2;
      clip3 <= clip2;
      // a degenerate source zeroes every field but its flag
      degenerate <= det_zero;
      if (det_zero) begin
        bary_u     <= '0;
        bary_v     <= '0;
        bary_w     <= '0;
        inside_res <= 1'b0;
        mapped_x   <= '0;
        mapped_y   <= '0;
        mapped_z   <= '0;
        saturated  <= 1'b0;
      end else begin
        bary_u     <= wt3[0];
        bary_v     <= wt3[1];
        bary_w     <= wt3[2];
        inside_res <= ins3;
        mapped_x   <= msat[0];
        mapped_y   <= msat[1];
        mapped_z   <= msat[2];
        saturated  <= clip3 | mclip;
      end
    end
  end

  // weights travel alongside the products and sums
  always_ff @(posedge clk) begin
    if (en) begin
      wt2 <= wt;
      wt3 <= wt2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld     <= {vld[1:0], in_vld};
      out_vld <= vld[2];
    end
  end
endmodule

### sv/tbm_checker.sv
// ---------------------------------------------------------------------------
// Triangle barycentric map: port checker
// Handshake and result consistency checks, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_barycentric_map_macros.svh"

module tbm_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             pt_ready,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic signed [tbm_pkg::WBITS-1:0] bary_u,
  input logic signed [tbm_pkg::WBITS-1:0] bary_v,
  input logic signed [tbm_pkg::WBITS-1:0] bary_w,
  input logic                             inside_res,
  input logic                             degenerate,
  input logic                             saturated
);
  `TBM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result word dropped while stalled")
  `TBM_ASSERT_NEXT(a_cfg_blocks, cfg_valid && cfg_ready, !pt_ready, "point taken during setup")
  `TBM_ASSERT_ALWAYS_NEXT(a_rst_blocks, rst, !pt_ready, "point ready right after reset")
  `TBM_ASSERT_NOW(a_degen_clean, res_valid && degenerate, bary_u == 0 && bary_v == 0 && bary_w == 0 && !inside_res && !saturated, "degenerate result carries data")
endmodule

bind triangle_barycentric_map tbm_checker u_tbm_checker (
  .clk(clk), .rst(rst), .pt_ready(point.ready),
  .cfg_valid(cfg.valid), .cfg_ready(cfg.ready),
  .res_valid(result.valid), .res_ready(result.ready),
  .bary_u(result.bary_u), .bary_v(result.bary_v), .bary_w(result.bary_w),
  .inside_res(result.inside_res), .degenerate(result.degenerate),
  .saturated(result.saturated)
);

### tb/triangle_barycentric_map_tb.sv
// ---------------------------------------------------------------------------
// Triangle barycentric map testbench
// Drives query points through the point channel and reconfigures the source
// and target triangles between phases. A local fixed-point predictor works
// out the weights, flags and mapped point of every accepted point. A monitor
// checks each result word against the oldest pending prediction, under
// random sender gaps, receiver stalls and one long receiver hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_barycentric_map_tb;

  localparam int CB = tbm_pkg::COORD_BITS_DEF;
  localparam int WF = tbm_pkg::WEIGHT_FRAC_BITS_DEF;
  localparam int WB = tbm_pkg::WBITS;
  localparam logic [tbm_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;   // past the map
  localparam longint COORD_MAX = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint COORD_MIN = -(64'sd1 <<< (CB - 1));
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PIPE_DRAIN  = 80;

  typedef struct packed {
    logic signed [WB-1:0]    bary_u;
    logic signed [WB-1:0]    bary_v;
    logic signed [WB-1:0]    bary_w;
    logic                    inside_res;
    logic                    degenerate;
    logic signed [CB-1:0]    mapped_x;
    logic signed [CB-1:0]    mapped_y;
    logic signed [CB-1:0]    mapped_z;
    logic                    saturated;
  } mapping_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  tbm_point_if  pt ();
  tbm_result_if res ();
  tbm_cfg_if    cfg_ch ();

  triangle_barycentric_map dut (
    .clk    (clk),
    .rst    (rst),
    .point  (pt),
    .result (res),
    .cfg    (cfg_ch)
  );

  // Shadow of the register file and the geometry derived from it.
  logic [3*CB-1:0]      vertex_reg [6];
  tbm_pkg::mode_t       dim_mode;
  longint               dot00, dot01, dot11;
  logic signed [127:0]  gram_det;

  mapping_t pending_maps [$];
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       error_count = 0;
  int       points_sent = 0;
  int       results_seen = 0;
  int       degenerate_seen = 0;
  int       inside_seen = 0;
  int       saturated_seen = 0;
  int       cycle_count = 0;
  logic     hold_toggle = 1'b0;
  logic     dummy_flag;

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------
  function automatic longint vertex_coord(logic [3*CB-1:0] v, int k, logic three_d);
    logic signed [CB-1:0] c;
    if (k == 2 && !three_d) return 0;
    c = v[k*CB +: CB];
    return longint'(c);
  endfunction

  function automatic logic signed [127:0] wide_mul(longint a, longint b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // Recompute the source edge dot products and the Gram determinant.
  function automatic void derive_geometry();
    longint e0 [3];
    longint e1 [3];
    longint a;
    for (int k = 0; k < 3; k++) begin
      a = vertex_coord(vertex_reg[0], k, dim_mode.src_3d);
      e0[k] = vertex_coord(vertex_reg[1], k, dim_mode.src_3d) - a;
      e1[k] = vertex_coord(vertex_reg[2], k, dim_mode.src_3d) - a;
    end
    dot00 = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
    dot01 = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
    dot11 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
    gram_det = wide_mul(dot00, dot11) - wide_mul(dot01, dot01);
  endfunction

  // Truncated (num << WF) / det, magnitude clamped to 2^40.
  function automatic longint weight_quotient(logic signed [127:0] num);
    logic        neg;
    logic [127:0] mag, q;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag << WF) / $unsigned(gram_det);
    if (q > (128'd1 << tbm_pkg::QCLAMP_LOG)) q = 128'd1 << tbm_pkg::QCLAMP_LOG;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(longint x, int bits, ref logic flag);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (x < lo) begin
      flag = 1'b1;
      return lo;
    end
    return x;
  endfunction

  function automatic mapping_t predict_mapping(logic signed [CB-1:0] px,
                                               logic signed [CB-1:0] py,
                                               logic signed [CB-1:0] pz);
    mapping_t r;
    longint   p [3];
    longint   wt [3];
    longint   mp [3];
    longint   a, e0, e1, e2, d20, d21, acc, one;
    logic     in_tri, sat_flag;
    r = '0;
    if (gram_det == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    p[0] = px;
    p[1] = py;
    p[2] = dim_mode.src_3d ? longint'(pz) : 0;
    d20 = 0;
    d21 = 0;
    for (int k = 0; k < 3; k++) begin
      a  = vertex_coord(vertex_reg[0], k, dim_mode.src_3d);
      e0 = vertex_coord(vertex_reg[1], k, dim_mode.src_3d) - a;
      e1 = vertex_coord(vertex_reg[2], k, dim_mode.src_3d) - a;
      e2 = p[k] - a;
      d20 += e2 * e0;
      d21 += e2 * e1;
    end
    one = 64'sd1 <<< WF;
    wt[1] = weight_quotient(wide_mul(dot11, d20) - wide_mul(dot01, d21));
    wt[2] = weight_quotient(wide_mul(dot00, d21) - wide_mul(dot01, d20));
    wt[0] = one - wt[1] - wt[2];
    in_tri = 1'b1;
    sat_flag = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (!(wt[k] > 0 && wt[k] < one)) in_tri = 1'b0;
      wt[k] = clip(wt[k], WB, sat_flag);
    end
    for (int k = 0; k < 3; k++) begin
      mp[k] = 0;
      if (k < 2 || dim_mode.dst_3d) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += wt[j] * vertex_coord(vertex_reg[3+j], k, 1'b1);
        mp[k] = clip(acc >>> WF, CB, sat_flag);
      end
    end
    r.bary_u     = wt[0][WB-1:0];
    r.bary_v     = wt[1][WB-1:0];
    r.bary_w     = wt[2][WB-1:0];
    r.inside_res = in_tri;
    r.mapped_x   = mp[0][CB-1:0];
    r.mapped_y   = mp[1][CB-1:0];
    r.mapped_z   = mp[2][CB-1:0];
    r.saturated  = sat_flag;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off started by a toggle
  // -------------------------------------------------------------------------
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= 400;
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: compare each result word with the oldest prediction.
  always @(posedge clk) begin
    mapping_t got, want;
    if (!rst && res.valid && res.ready) begin
      got = '{res.bary_u, res.bary_v, res.bary_w, res.inside_res, res.degenerate,
              res.mapped_x, res.mapped_y, res.mapped_z, res.saturated};
      results_seen++;
      if (got.degenerate) degenerate_seen++;
      if (got.inside_res) inside_seen++;
      if (got.saturated) saturated_seen++;
      if (pending_maps.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("[%0t] result word with nothing pending", $realtime);
      end else begin
        want = pending_maps.pop_front();
        if (got.bary_u !== want.bary_u || got.bary_v !== want.bary_v ||
            got.bary_w !== want.bary_w || got.inside_res !== want.inside_res ||
            got.degenerate !== want.degenerate || got.mapped_x !== want.mapped_x ||
            got.mapped_y !== want.mapped_y || got.mapped_z !== want.mapped_z ||
            got.saturated !== want.saturated) begin
          error_count++;
          if (error_count <= 10) begin
            $display("[%0t] mismatch u/v/w exp %0d %0d %0d got %0d %0d %0d", $realtime,
                     want.bary_u, want.bary_v, want.bary_w, got.bary_u, got.bary_v, got.bary_w);
            $display("  in/deg/sat exp %b%b%b got %b%b%b  xyz exp %0d %0d %0d got %0d %0d %0d",
                     want.inside_res, want.degenerate, want.saturated,
                     got.inside_res, got.degenerate, got.saturated,
                     want.mapped_x, want.mapped_y, want.mapped_z,
                     got.mapped_x, got.mapped_y, got.mapped_z);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words pending", cycle_count, pending_maps.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------
  // Offer one point; hold valid high across back-to-back words.
  task automatic send_point(longint px, longint py, longint pz);
    logic signed [CB-1:0] cx, cy, cz;
    cx = px[CB-1:0];
    cy = py[CB-1:0];
    cz = pz[CB-1:0];
    while ($urandom_range(99) < idle_pct) begin
      pt.valid <= 1'b0;
      @(posedge clk);
    end
    pt.valid   <= 1'b1;
    pt.point_x <= cx;
    pt.point_y <= cy;
    pt.point_z <= cz;
    @(posedge clk);
    while (!pt.ready) @(posedge clk);
    pending_maps.push_back(predict_mapping(cx, cy, cz));
    points_sent++;
  endtask

  task automatic wait_drained();
    pt.valid <= 1'b0;
    @(posedge clk);
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // Write one register once the pipe is empty.
  task automatic write_reg(logic [tbm_pkg::CFG_INDEX_BITS-1:0] idx, logic [3*CB-1:0] value);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == tbm_pkg::REG_MODE) dim_mode = tbm_pkg::mode_t'(value[1:0]);
    else if (idx < tbm_pkg::REG_MODE) vertex_reg[idx] = value;
    derive_geometry();
  endtask

  function automatic logic [3*CB-1:0] pack_vertex(longint x, longint y, longint z);
    logic [CB-1:0] cx, cy, cz;
    cx = x[CB-1:0];
    cy = y[CB-1:0];
    cz = z[CB-1:0];
    return {cz, cy, cx};
  endfunction

  function automatic longint rand_coord(int span);
    return longint'($urandom_range(2 * span)) - span;
  endfunction

  task automatic set_triangles(logic [3*CB-1:0] sa, logic [3*CB-1:0] sb, logic [3*CB-1:0] sc,
                               logic [3*CB-1:0] ta, logic [3*CB-1:0] tb,
                               logic [3*CB-1:0] tc);
    write_reg(tbm_pkg::REG_SRC_A, sa);
    write_reg(tbm_pkg::REG_SRC_B, sb);
    write_reg(tbm_pkg::REG_SRC_C, sc);
    write_reg(tbm_pkg::REG_DST_A, ta);
    write_reg(tbm_pkg::REG_DST_B, tb);
    write_reg(tbm_pkg::REG_DST_C, tc);
  endtask

  // Random triangles, mostly within +/-16384, sometimes full range.
  task automatic random_triangles();
    int span;
    span = ($urandom_range(9) == 0) ? int'(COORD_MAX) : 16384;
    set_triangles(pack_vertex(rand_coord(span), rand_coord(span), rand_coord(span)),
                  pack_vertex(rand_coord(span), rand_coord(span), rand_coord(span)),
                  pack_vertex(rand_coord(span), rand_coord(span), rand_coord(span)),
                  pack_vertex(rand_coord(span), rand_coord(span), rand_coord(span)),
                  pack_vertex(rand_coord(span), rand_coord(span), rand_coord(span)),
                  pack_vertex(rand_coord(span), rand_coord(span), rand_coord(span)));
  endtask

  // Most points near the source triangle, the rest anywhere.
  task automatic random_point();
    longint cx, cy, cz;
    if ($urandom_range(4) == 0) begin
      send_point(longint'($urandom), longint'($urandom), longint'($urandom));
    end else begin
      cx = 0;
      cy = 0;
      cz = 0;
      for (int j = 0; j < 3; j++) begin
        cx += vertex_coord(vertex_reg[j], 0, 1'b1);
        cy += vertex_coord(vertex_reg[j], 1, 1'b1);
        cz += vertex_coord(vertex_reg[j], 2, 1'b1);
      end
      send_point(clip(cx / 3 + rand_coord(12000), CB, dummy_flag),
                 clip(cy / 3 + rand_coord(12000), CB, dummy_flag),
                 clip(cz / 3 + rand_coord(12000), CB, dummy_flag));
    end
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  // All vertices zero after reset: every point is degenerate.
  task automatic test_reset_degenerate();
    send_point(0, 0, 0);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN);
  endtask

  // Right triangle of side 4096 mapped onto another triangle: corners, edges, centroid,
  // outside points, extremes, and a write past the register map.
  task automatic test_directed();
    set_triangles(pack_vertex(0, 0, 0), pack_vertex(4096, 0, 0), pack_vertex(0, 4096, 0),
                  pack_vertex(8192, 8192, 4096), pack_vertex(-8192, 0, 0),
                  pack_vertex(0, -8192, 12288));
    write_reg(REG_UNUSED, '1);
    send_point(0, 0, 0);
    send_point(4096, 0, 0);
    send_point(0, 4096, 0);
    send_point(1365, 1365, 0);
    send_point(2048, 2048, 0);
    send_point(2048, 0, 0);
    send_point(-100, 500, 0);
    send_point(1000, 1000, 777);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MIN, 0);
  endtask

  // Collinear source and full-range target to force clipping.
  task automatic test_special_geometry();
    set_triangles(pack_vertex(0, 0, 0), pack_vertex(4096, 4096, 0),
                  pack_vertex(8192, 8192, 0), pack_vertex(COORD_MAX, COORD_MIN, COORD_MAX),
                  pack_vertex(COORD_MIN, COORD_MAX, COORD_MIN), pack_vertex(COORD_MAX, 0, 0));
    send_point(100, 200, 0);
    // Tiny source triangle: weights far outside clip to the 24-bit range.
    write_reg(tbm_pkg::REG_SRC_B, pack_vertex(1, 0, 0));
    write_reg(tbm_pkg::REG_SRC_C, pack_vertex(0, 1, 0));
    send_point(COORD_MAX, COORD_MAX, 0);
    send_point(COORD_MIN, 3, 0);
    send_point(2, 2, 0);
  endtask

  // Every dimension mode, with z carrying data to be ignored or used.
  task automatic test_dimension_modes();
    set_triangles(pack_vertex(0, 0, 4096), pack_vertex(4096, 0, -4096),
                  pack_vertex(0, 4096, 8192), pack_vertex(1000, 2000, 3000),
                  pack_vertex(-4000, 5000, -6000), pack_vertex(7000, -8000, 9000));
    for (int m = 0; m < 4; m++) begin
      write_reg(tbm_pkg::REG_MODE, 60'(m));
      send_point(1000, 1200, 300);
      send_point(-2000, 500, -4096);
    end
  endtask

  task automatic test_random_phase(int pct_idle, int pct_stall, int count);
    idle_pct = pct_idle;
    stall_pct = pct_stall;
    random_triangles();
    write_reg(tbm_pkg::REG_MODE, 60'($urandom_range(3)));
    for (int i = 0; i < count; i++) random_point();
  endtask

  // Long receiver hold-off while points keep coming, then a full drain and more points.
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    random_triangles();
    hold_toggle <= ~hold_toggle;
    for (int i = 0; i < 60; i++) random_point();
    wait_drained();
    for (int i = 0; i < 20; i++) random_point();
  endtask

  initial begin
    pt.valid = 1'b0;
    pt.point_x = '0;
    pt.point_y = '0;
    pt.point_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = tbm_pkg::REG_SRC_A;
    cfg_ch.data = '0;
    for (int i = 0; i < 6; i++) vertex_reg[i] = '0;
    dim_mode = tbm_pkg::MODE_RESET;
    derive_geometry();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_degenerate();
    test_directed();
    test_special_geometry();
    test_dimension_modes();
    for (int r = 0; r < 2; r++) begin
      test_random_phase(0, 0, 120);
      test_random_phase(76, 0, 120);
      test_random_phase(0, 76, 120);
      test_random_phase(17, 17, 120);
    end
    test_backpressure();

    wait_drained();
    $display("Mapped %0d points over random and directed triangles in all dimension modes;",
             points_sent);
    $display("  %0d results, %0d degenerate, %0d inside, %0d clipped, %0d errors",
             results_seen, degenerate_seen, inside_seen, saturated_seen, error_count);
    if (error_count == 0 && pending_maps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
